FILE: hw/rtl/pfa_pkg.sv
// pfa_pkg: shared types, command codes and saturation helper for the
// potential field force accumulator. No dependencies.
package pfa_pkg;

  localparam int unsigned SumW      = 48;
  localparam int unsigned DivSteps  = 48;
  localparam int unsigned SqrtSteps = 32;

  typedef enum logic [2:0] {
    CFG_ATTRACT = 3'd0,
    CFG_REPEL   = 3'd1,
    CFG_SAFE    = 3'd2,
    CFG_MASS    = 3'd3,
    CFG_MISSION = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MUL_SQ, MUL_ATT, MUL_D2, MUL_D3L, MUL_D3H, MUL_REP
  } mul_op_e;

  typedef enum logic [3:0] {
    ACT_NONE, ACT_LOAD, ACT_SQ_ADD, ACT_ATT, ACT_SQRT_INIT, ACT_SQRT_STEP,
    ACT_D2, ACT_DEN_LO, ACT_DEN_HI, ACT_RLOAD, ACT_DIV_STEP, ACT_REP_APPLY,
    ACT_OLOAD, ACT_OSTORE, ACT_EMIT
  } act_op_e;

  typedef struct packed {
    mul_op_e    mul_op;
    act_op_e    act;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic rep_en;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [31:0] attract;
    logic [31:0] repel;
    logic [31:0] safe;
    logic [31:0] mass;
    logic        mission;
  } cfg_t;

  // add a 50-bit term into a 48-bit sum, clamp to the 48-bit signed range
  function automatic logic signed [SumW-1:0] sat_add(logic signed [SumW-1:0] sum,
                                                      logic signed [49:0] term);
    logic signed [50:0] s;
    s = 51'(sum) + 51'(term);
    if (s > 51'sh7FFF_FFFF_FFFF) begin
      return {1'b0, {(SumW-1){1'b1}}};
    end else if (s < -51'sh8000_0000_0000) begin
      return {1'b1, {(SumW-1){1'b0}}};
    end
    return s[SumW-1:0];
  endfunction

endpackage

FILE: hw/rtl/pfa_datapath.sv
// pfa_datapath: shared 32x32 multiplier, square root and restoring divider
// units, force sums and result register. Depends on pfa_pkg.
module pfa_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pfa_pkg::cmd_t   cmd_i,
  input  pfa_pkg::cfg_t   cfg_i,
  input  logic [111:0]    in_data_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic [95:0]     out_data_o,
  output pfa_pkg::sts_t   sts_o
);

  logic              neg_q [3];
  logic [31:0]       mag_q [3];
  logic              hop_diff_q;
  logic [63:0]       prod_q, prod_d;
  logic [63:0]       sq_q, sv_q, sr_q, sbit_q, d2_q;
  logic [95:0]       den_q, dr_q, dn_q, dden_q;
  logic [47:0]       dq_q;
  logic              dovf_q;
  logic signed [47:0] sum_q [3];
  logic [31:0]       acc_q [3];
  logic [95:0]       out_q;
  logic              out_valid_q;

  logic [31:0]  op_a, op_b;
  logic [63:0]  trial;
  logic [96:0]  dt, ddiff;
  logic         dge;
  logic [95:0]  ld_num, ld_den;
  logic [47:0]  sum_mag, qcap;
  logic [31:0]  d;
  logic signed [47:0] cur_sum;
  logic         cur_neg;

  assign d       = sr_q[31:0];
  assign cur_sum = sum_q[cmd_i.axis];
  assign cur_neg = neg_q[cmd_i.axis];

  always_comb begin
    case (cmd_i.mul_op)
      pfa_pkg::MUL_SQ:  begin op_a = mag_q[cmd_i.axis]; op_b = mag_q[cmd_i.axis]; end
      pfa_pkg::MUL_ATT: begin op_a = cfg_i.attract;     op_b = mag_q[cmd_i.axis]; end
      pfa_pkg::MUL_D2:  begin op_a = d;                 op_b = d; end
      pfa_pkg::MUL_D3L: begin op_a = d2_q[31:0];        op_b = d; end
      pfa_pkg::MUL_D3H: begin op_a = d2_q[63:32];       op_b = d; end
      pfa_pkg::MUL_REP: begin op_a = cfg_i.repel;       op_b = mag_q[cmd_i.axis]; end
      default:          begin op_a = '0;                op_b = '0; end
    endcase
    prod_d = {32'd0, op_a} * {32'd0, op_b};
  end

  // square root and divider step logic
  assign trial = sr_q + sbit_q;
  assign dt    = {dr_q, dn_q[95]};
  assign dge   = dt >= {1'b0, dden_q};
  assign ddiff = dt - {1'b0, dden_q};

  always_comb begin
    sum_mag = cur_sum[47] ? 48'(-cur_sum) : 48'(cur_sum);
    if (cmd_i.act == pfa_pkg::ACT_RLOAD) begin
      ld_num = {prod_q, 32'd0};
      ld_den = den_q;
    end else begin
      ld_num = {32'd0, sum_mag, 16'd0};
      ld_den = {64'd0, cfg_i.mass};
    end
    qcap = (dovf_q || dq_q > 48'h8000_0000_0000) ? 48'h8000_0000_0000 : dq_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int k = 0; k < 3; k++) sum_q[k] <= '0;
    end else begin
      if (cmd_i.act == pfa_pkg::ACT_EMIT) begin
        out_valid_q <= 1'b1;
        for (int k = 0; k < 3; k++) sum_q[k] <= '0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.act == pfa_pkg::ACT_ATT && hop_diff_q) begin
        sum_q[cmd_i.axis] <= pfa_pkg::sat_add(cur_sum,
            cur_neg ? -$signed({2'b00, prod_q[63:16]}) : $signed({2'b00, prod_q[63:16]}));
      end
      if (cmd_i.act == pfa_pkg::ACT_REP_APPLY) begin
        sum_q[cmd_i.axis] <= pfa_pkg::sat_add(cur_sum,
            cur_neg ? $signed({2'b00, qcap}) : -$signed({2'b00, qcap}));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (cmd_i.act)
      pfa_pkg::ACT_LOAD: begin
        for (int k = 0; k < 3; k++) begin
          neg_q[k] <= in_data_i[32*k+31];
          mag_q[k] <= in_data_i[32*k+31] ? 32'(0 - in_data_i[32*k +: 32])
                                         : in_data_i[32*k +: 32];
        end
        hop_diff_q <= in_data_i[103:96] != in_data_i[111:104];
        sq_q       <= '0;
      end
      pfa_pkg::ACT_SQ_ADD: sq_q <= sq_q + prod_q;
      pfa_pkg::ACT_SQRT_INIT: begin
        sv_q   <= sq_q;
        sr_q   <= '0;
        sbit_q <= 64'h4000_0000_0000_0000;
      end
      pfa_pkg::ACT_SQRT_STEP: begin
        if (sv_q >= trial) begin
          sv_q <= sv_q - trial;
          sr_q <= (sr_q >> 1) + sbit_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      pfa_pkg::ACT_D2:     d2_q  <= prod_q;
      pfa_pkg::ACT_DEN_LO: den_q <= {32'd0, prod_q};
      pfa_pkg::ACT_DEN_HI: den_q <= den_q + {prod_q, 32'd0};
      pfa_pkg::ACT_RLOAD, pfa_pkg::ACT_OLOAD: begin
        // upper part at or above the divisor means the quotient reaches 2^48
        dr_q   <= {48'd0, ld_num[95:48]};
        dn_q   <= {ld_num[47:0], 48'd0};
        dden_q <= ld_den;
        dovf_q <= {48'd0, ld_num[95:48]} >= ld_den;
        dq_q   <= '0;
      end
      pfa_pkg::ACT_DIV_STEP: begin
        dr_q <= dge ? ddiff[95:0] : dt[95:0];
        dn_q <= {dn_q[94:0], 1'b0};
        dq_q <= {dq_q[46:0], dge};
      end
      pfa_pkg::ACT_OSTORE: begin
        if (cur_sum == '0) begin
          acc_q[cmd_i.axis] <= '0;
        end else if (dovf_q || (|dq_q[47:31])) begin
          acc_q[cmd_i.axis] <= cur_sum[47] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          acc_q[cmd_i.axis] <= cur_sum[47] ? 32'(0 - dq_q[31:0]) : dq_q[31:0];
        end
      end
      pfa_pkg::ACT_EMIT: out_q <= cfg_i.mission ? {acc_q[2], acc_q[1], acc_q[0]} : '0;
      default: ;
    endcase
  end

  assign sts_o.rep_en   = (d != '0) && (d < cfg_i.safe);
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

FILE: hw/rtl/pfa_ctrl.sv
// pfa_ctrl: sequencer issuing multiplier, root and divider commands to the
// datapath. Depends on pfa_pkg.
module pfa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_has_i,
  input  logic          in_last_i,
  input  logic          mission_i,
  input  pfa_pkg::sts_t sts_i,
  output logic          in_ready_o,
  output pfa_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQM, S_SQA, S_ATM, S_ATA, S_SQI, S_SQRT, S_D2M, S_D2, S_D3L,
    S_D3H, S_DEN, S_RMUL, S_RLOAD, S_RDIV, S_RAPPLY, S_OLOAD, S_ODIV,
    S_OSTORE, S_EMIT
  } state_e;

  state_e     state_q;
  logic [1:0] k_q;
  logic [5:0] cnt_q;
  logic       last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      cnt_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          k_q <= '0;
          if (in_valid_i) begin
            last_q <= in_last_i;
            if (mission_i && in_has_i) state_q <= S_SQM;
            else if (in_last_i)        state_q <= mission_i ? S_OLOAD : S_EMIT;
          end
        end
        S_SQM: state_q <= S_SQA;
        S_SQA: begin
          if (k_q == 2'd2) begin
            k_q <= '0;
            state_q <= S_ATM;
          end else begin
            k_q <= k_q + 2'd1;
            state_q <= S_SQM;
          end
        end
        S_ATM: state_q <= S_ATA;
        S_ATA: begin
          if (k_q == 2'd2) begin
            k_q <= '0;
            state_q <= S_SQI;
          end else begin
            k_q <= k_q + 2'd1;
            state_q <= S_ATM;
          end
        end
        S_SQI: begin
          cnt_q   <= '0;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (cnt_q == 6'(pfa_pkg::SqrtSteps - 1)) begin
            cnt_q <= '0;
            state_q <= S_D2M;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_D2M: begin
          if (sts_i.rep_en)  state_q <= S_D2;
          else if (last_q)   state_q <= S_OLOAD;
          else               state_q <= S_IDLE;
        end
        S_D2:  state_q <= S_D3L;
        S_D3L: state_q <= S_D3H;
        S_D3H: state_q <= S_DEN;
        S_DEN: state_q <= S_RMUL;
        S_RMUL:  state_q <= S_RLOAD;
        S_RLOAD: begin
          cnt_q   <= '0;
          state_q <= S_RDIV;
        end
        S_RDIV: begin
          if (cnt_q == 6'(pfa_pkg::DivSteps - 1)) begin
            cnt_q <= '0;
            state_q <= S_RAPPLY;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_RAPPLY: begin
          if (k_q == 2'd2) begin
            k_q <= '0;
            state_q <= last_q ? S_OLOAD : S_IDLE;
          end else begin
            k_q <= k_q + 2'd1;
            state_q <= S_RMUL;
          end
        end
        S_OLOAD: begin
          cnt_q   <= '0;
          state_q <= S_ODIV;
        end
        S_ODIV: begin
          if (cnt_q == 6'(pfa_pkg::DivSteps - 1)) begin
            cnt_q <= '0;
            state_q <= S_OSTORE;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        S_OSTORE: begin
          if (k_q == 2'd2) begin
            k_q <= '0;
            state_q <= S_EMIT;
          end else begin
            k_q <= k_q + 2'd1;
            state_q <= S_OLOAD;
          end
        end
        S_EMIT: if (sts_i.out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.axis   = k_q;
    cmd_o.mul_op = pfa_pkg::MUL_SQ;
    cmd_o.act    = pfa_pkg::ACT_NONE;
    case (state_q)
      S_IDLE:   if (in_valid_i) cmd_o.act = pfa_pkg::ACT_LOAD;
      S_SQM:    cmd_o.mul_op = pfa_pkg::MUL_SQ;
      S_SQA:    cmd_o.act = pfa_pkg::ACT_SQ_ADD;
      S_ATM:    cmd_o.mul_op = pfa_pkg::MUL_ATT;
      S_ATA:    cmd_o.act = pfa_pkg::ACT_ATT;
      S_SQI:    cmd_o.act = pfa_pkg::ACT_SQRT_INIT;
      S_SQRT:   cmd_o.act = pfa_pkg::ACT_SQRT_STEP;
      S_D2M:    cmd_o.mul_op = pfa_pkg::MUL_D2;
      S_D2:     cmd_o.act = pfa_pkg::ACT_D2;
      S_D3L:    cmd_o.mul_op = pfa_pkg::MUL_D3L;
      S_D3H: begin
        cmd_o.mul_op = pfa_pkg::MUL_D3H;
        cmd_o.act    = pfa_pkg::ACT_DEN_LO;
      end
      S_DEN:    cmd_o.act = pfa_pkg::ACT_DEN_HI;
      S_RMUL:   cmd_o.mul_op = pfa_pkg::MUL_REP;
      S_RLOAD:  cmd_o.act = pfa_pkg::ACT_RLOAD;
      S_RDIV:   cmd_o.act = pfa_pkg::ACT_DIV_STEP;
      S_RAPPLY: cmd_o.act = pfa_pkg::ACT_REP_APPLY;
      S_OLOAD:  cmd_o.act = pfa_pkg::ACT_OLOAD;
      S_ODIV:   cmd_o.act = pfa_pkg::ACT_DIV_STEP;
      S_OSTORE: cmd_o.act = pfa_pkg::ACT_OSTORE;
      S_EMIT:   if (sts_i.out_free) cmd_o.act = pfa_pkg::ACT_EMIT;
      default:  cmd_o.act = pfa_pkg::ACT_NONE;
    endcase
  end

  assign in_ready_o = state_q == S_IDLE;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.act == pfa_pkg::ACT_EMIT |-> sts_i.out_free)
    else $error("result written while previous result still pending");

  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q != 2'd3)
    else $error("axis counter out of range");

  // root init state, then 32 root steps, then the d^2 multiply state
  a_sqrt_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SQI |-> ##33 state_q == S_D2M)
    else $error("square root did not take its full step count");

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.act == pfa_pkg::ACT_LOAD |=> state_q != S_EMIT || $past(in_last_i))
    else $error("result emitted for an item without last mark");

endmodule

FILE: hw/rtl/potential_field_force_accumulator.sv
// potential_field_force_accumulator: top level with configuration registers,
// sequencer and datapath. Depends on pfa_pkg, pfa_ctrl, pfa_datapath.
//
//  channel   | direction | contents
//  s_axis    | in        | neighbor offsets, hop counts, has_neighbor, last mark
//  m_axis    | out       | acceleration x, y, z
//  cfg       | in        | register writes, no read-back
//
// a neighbor transaction runs six multiplies and a 32-step root before the next
// acceptance; inside the safe distance it adds the distance and repel multiplies
// and three 48-step divides; with mission on, a last item adds the three mass
// divides and the result write, plus any wait for the previous result to be taken
// all multiplies go through one multiplier and all divides through one bit-serial divider
// s_axis_tready_o is high only while the sequencer is idle; a finished
// result waits in its own register so the next item can be taken
// reset (rst_ni low, asynchronous) clears the sums and restores the register defaults
module potential_field_force_accumulator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // offset_x, offset_y, offset_z, neighbor_hop_count, own_hop_count
  input  logic [111:0] s_axis_tdata_i,
  input  logic         s_axis_tlast_i,
  // has_neighbor
  input  logic         s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // accel_x, accel_y, accel_z
  output logic [95:0]  m_axis_tdata_o,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  pfa_pkg::cfg_t cfg_q;
  pfa_pkg::cmd_t cmd;
  pfa_pkg::sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attract <= 32'd65536;
      cfg_q.repel   <= 32'd65536;
      cfg_q.safe    <= 32'd327680;
      cfg_q.mass    <= 32'd65536;
      cfg_q.mission <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pfa_pkg::CFG_ATTRACT: cfg_q.attract <= cfg_data_i;
        pfa_pkg::CFG_REPEL:   cfg_q.repel   <= cfg_data_i;
        pfa_pkg::CFG_SAFE:    cfg_q.safe    <= cfg_data_i;
        pfa_pkg::CFG_MASS:    cfg_q.mass    <= cfg_data_i;
        pfa_pkg::CFG_MISSION: cfg_q.mission <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  pfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_has_i   (s_axis_tuser_i),
    .in_last_i  (s_axis_tlast_i),
    .mission_i  (cfg_q.mission),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  pfa_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_i       (cfg_q),
    .in_data_i   (s_axis_tdata_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .sts_o       (sts)
  );

endmodule

FILE: verif/pfa_checker.sv
// pfa_checker: watches the config port and both stream channels of the force
// accumulator, predicts each acceleration and compares it. Depends on pfa_pkg.
module pfa_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  // offset_x, offset_y, offset_z, neighbor_hop_count, own_hop_count
  input  logic [111:0] s_axis_tdata_i,
  input  logic         s_axis_tlast_i,
  // has_neighbor
  input  logic         s_axis_tuser_i,
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  // accel_x, accel_y, accel_z
  input  logic [95:0]  m_axis_tdata_i,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  output int           fail_count_o,
  output int           accel_pending_o
);

  localparam longint ForceMax = 64'sd140737488355327;
  localparam longint ForceMin = -64'sd140737488355328;
  localparam bit [63:0] TermCap = 64'd1 << 47;

  bit [31:0] attract_gain, repel_gain, safe_dist, mass;
  bit        mission;
  longint    force_sum [3];
  bit [95:0] accel_q [$];

  function automatic longint sat_force(longint a, longint b);
    longint s;
    s = a + b;
    if (s > ForceMax) return ForceMax;
    if (s < ForceMin) return ForceMin;
    return s;
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit [31:0] mass_divide(longint s);
    bit        neg;
    bit [63:0] m, q;
    neg = s < 0;
    m = neg ? 64'(-s) : 64'(s);
    if (m == 0) return 32'd0;
    if (mass == 0) q = 64'd1 << 40;
    else q = (m << 16) / {32'd0, mass};
    if (neg) return (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  task automatic accumulate(bit [111:0] data, bit has, bit last);
    bit        neg [3];
    bit [63:0] mag [3];
    bit [63:0] sq, d, t;
    bit [127:0] num, den, q;
    sq = 0;
    if (mission && has) begin
      for (int k = 0; k < 3; k++) begin
        neg[k] = data[32*k+31];
        mag[k] = neg[k] ? (64'd1 << 32) - {32'd0, data[32*k +: 32]} : {32'd0, data[32*k +: 32]};
        sq = sq + mag[k] * mag[k];
      end
      if (data[103:96] != data[111:104]) begin
        for (int k = 0; k < 3; k++) begin
          t = ({32'd0, attract_gain} * mag[k]) >> 16;
          force_sum[k] = sat_force(force_sum[k], neg[k] ? -longint'(t) : longint'(t));
        end
      end
      d = int_sqrt(sq);
      if (d != 0 && d < {32'd0, safe_dist}) begin
        den = {64'd0, d} * {64'd0, d} * {64'd0, d};
        for (int k = 0; k < 3; k++) begin
          num = {64'd0, {32'd0, repel_gain} * mag[k]} << 32;
          q = num / den;
          t = (q > {64'd0, TermCap}) ? TermCap : q[63:0];
          force_sum[k] = sat_force(force_sum[k], neg[k] ? longint'(t) : -longint'(t));
        end
      end
    end
    if (last) begin
      if (mission) begin
        accel_q.push_back({mass_divide(force_sum[2]), mass_divide(force_sum[1]),
                           mass_divide(force_sum[0])});
      end else begin
        accel_q.push_back(96'd0);
      end
      for (int k = 0; k < 3; k++) force_sum[k] = 0;
    end
  endtask

  task automatic report(string what, bit [31:0] got, bit [31:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bit [95:0] want;
    if (!rst_ni) begin
      attract_gain = 32'd65536;
      repel_gain = 32'd65536;
      safe_dist = 32'd327680;
      mass = 32'd65536;
      mission = 1'b0;
      for (int k = 0; k < 3; k++) force_sum[k] = 0;
      accel_q.delete();
      fail_count_o = 0;
      accel_pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pfa_pkg::CFG_ATTRACT: attract_gain = cfg_data_i;
          pfa_pkg::CFG_REPEL:   repel_gain = cfg_data_i;
          pfa_pkg::CFG_SAFE:    safe_dist = cfg_data_i;
          pfa_pkg::CFG_MASS:    mass = cfg_data_i;
          pfa_pkg::CFG_MISSION: mission = cfg_data_i[0];
          default: ;
        endcase
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (accel_q.size() == 0) begin
          report("unexpected result", m_axis_tdata_i[31:0], 32'd0);
        end else begin
          want = accel_q.pop_front();
          if (m_axis_tdata_i[31:0] != want[31:0])
            report("accel_x", m_axis_tdata_i[31:0], want[31:0]);
          if (m_axis_tdata_i[63:32] != want[63:32])
            report("accel_y", m_axis_tdata_i[63:32], want[63:32]);
          if (m_axis_tdata_i[95:64] != want[95:64])
            report("accel_z", m_axis_tdata_i[95:64], want[95:64]);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        accumulate(s_axis_tdata_i, s_axis_tuser_i, s_axis_tlast_i);
      accel_pending_o = accel_q.size();
    end
  end

endmodule

FILE: verif/tb.sv
// tb: stimulus and verdict for potential_field_force_accumulator; checking is
// done by pfa_checker. Depends on pfa_pkg, pfa_checker and the block's RTL.
module tb;

  localparam int StallLimit = 20000;
  localparam int Settle = 600;

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid_i, s_axis_tready_o, s_axis_tlast_i, s_axis_tuser_i;
  logic [111:0] s_axis_tdata_i;
  logic         m_axis_tvalid_o, m_axis_tready_i;
  logic [95:0]  m_axis_tdata_o;
  logic         cfg_we_i;
  logic [2:0]   cfg_idx_i;
  logic [31:0]  cfg_data_i;
  int           fail_count, accel_pending, idle_cycles, stall_left;
  bit           calm;

  potential_field_force_accumulator dut (.*);

  pfa_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .s_axis_tlast_i, .s_axis_tuser_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .accel_pending_o(accel_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // no-progress watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver backpressure in bursts
  always @(negedge clk_i) begin
    if (!rst_ni || calm) begin
      m_axis_tready_i <= rst_ni;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  task automatic write_reg(pfa_pkg::cfg_idx_e idx, bit [31:0] value);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_all(bit [31:0] att, bit [31:0] rep, bit [31:0] safe, bit [31:0] m,
                         bit on);
    write_reg(pfa_pkg::CFG_ATTRACT, att);
    write_reg(pfa_pkg::CFG_REPEL, rep);
    write_reg(pfa_pkg::CFG_SAFE, safe);
    write_reg(pfa_pkg::CFG_MASS, m);
    write_reg(pfa_pkg::CFG_MISSION, {31'd0, on});
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(bit [31:0] x, bit [31:0] y, bit [31:0] z, bit [7:0] nh,
                           bit [7:0] oh, bit has, bit last);
    bit took;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i = {oh, nh, z, y, x};
    s_axis_tuser_i = has;
    s_axis_tlast_i = last;
    do begin
      @(posedge clk_i);
      took = s_axis_tready_o;
      @(negedge clk_i);
    end while (!took);
    s_axis_tvalid_i = 1'b0;
  endtask

  function automatic bit [31:0] rand_offset();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      2: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      3: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return $urandom_range(0, 1) ? 32'd0 : 32'($signed($urandom_range(0, 6)) - 3);
    endcase
  endfunction

  task automatic send_random(bit force_last);
    bit [7:0] nh, oh;
    nh = 8'($urandom);
    oh = $urandom_range(0, 1) ? nh : 8'($urandom);
    send_item(rand_offset(), rand_offset(), rand_offset(), nh, oh,
              $urandom_range(0, 9) != 0, force_last || $urandom_range(0, 5) == 0);
  endtask

  task automatic drain();
    while (accel_pending != 0) @(negedge clk_i);
    repeat (Settle) @(negedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tlast_i = 1'b0;
    s_axis_tuser_i = 1'b0;
    m_axis_tready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = pfa_pkg::CFG_ATTRACT;
    cfg_data_i = '0;
    idle_cycles = 0;
    calm = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // mission off after reset: neighbors add nothing, the result is zero
    send_item(32'h0001_0000, 32'h0002_0000, 32'h0, 8'd1, 8'd2, 1'b1, 1'b0);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 8'd3, 8'd3, 1'b1, 1'b1);
    drain();

    set_all(32'd65536, 32'd65536, 32'd327680, 32'd65536, 1'b1);
    // directed corners
    send_item(32'h0001_0000, 32'h0, 32'h0, 8'd1, 8'd2, 1'b1, 1'b1);
    send_item(32'h0, 32'h0, 32'h0, 8'd0, 8'd255, 1'b1, 1'b1);
    send_item(32'h0001_0000, 32'h0001_0000, 32'h0, 8'd5, 8'd5, 1'b0, 1'b1);
    send_item(32'h0, 32'h0, 32'h0, 8'd0, 8'd0, 1'b0, 1'b1);
    send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd0, 8'd1, 1'b1, 1'b0);
    send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd0, 8'd1, 1'b1, 1'b1);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'd255, 8'd0, 1'b1, 1'b1);
    send_item(32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 8'd7, 8'd7, 1'b1, 1'b1);
    send_item(32'h0000_8000, 32'hFFFF_8000, 32'h0002_0000, 8'd9, 8'd7, 1'b1, 1'b0);
    send_item(32'hFFFE_0000, 32'h0000_4000, 32'h0, 8'd7, 8'd7, 1'b1, 1'b1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: ;
        1: set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b1);
        2: set_all(32'd1, 32'd1, 32'd1, 32'hFFFF_FFFF, 1'b1);
        3: set_all(32'h8000, 32'h0040_0000, 32'h0040_0000, 32'h0003_0000, 1'b1);
        4: set_all($urandom, $urandom, $urandom_range(1, 32'h00FF_FFFF), $urandom, 1'b0);
        default: set_all($urandom_range(1, 32'h0010_0000), $urandom_range(1, 32'h0100_0000),
                         $urandom_range(32'h1_0000, 32'h0100_0000),
                         $urandom_range(1, 32'h0004_0000), 1'b1);
      endcase
      for (int n = 0; n < 270; n++) begin
        if (ph == 2 && n == 135) begin
          send_random(1'b1);
          while (accel_pending != 0) @(negedge clk_i);
        end
        if (ph == 5 && n == 135) calm = 1'b1;
        send_random(n == 269);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_datapath.sv
hw/rtl/pfa_ctrl.sv
hw/rtl/potential_field_force_accumulator.sv
verif/pfa_checker.sv
verif/tb.sv
